[hdl/tdd_pkg.sv]
// ----------------------------------------------------------------------------
// Tile damage detector package
// Shared types, register indexes and helper functions of the detector.
// ----------------------------------------------------------------------------
package tdd_pkg;

  localparam int unsigned DimW    = 14;
  localparam int unsigned CoordW  = 13;
  localparam int unsigned PixW    = 32;
  localparam int unsigned PbW     = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegSurfaceWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSurfaceHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTileWidth     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTileHeight    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPixelBytes    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegHavePrevious  = 3'd5;

  typedef struct packed {
    logic [DimW-1:0] sw;
    logic [DimW-1:0] sh;
    logic [DimW-1:0] tw;
    logic [DimW-1:0] th;
    logic [PbW-1:0]  pb;
    logic            hp;
  } cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] top;
    logic [DimW-1:0]   height;
    logic              frame_end;
    logic              full;
  } job_info_t;

  localparam int unsigned JobInfoW = $bits(job_info_t);

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] lim);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > lim) begin
      r = lim;
    end
    return r;
  endfunction

  function automatic logic [PbW-1:0] clamp_bytes(input logic [PbW-1:0] v);
    logic [PbW-1:0] r;
    r = v;
    if (v == '0) begin
      r = PbW'(1);
    end else if (v > PbW'(4)) begin
      r = PbW'(4);
    end
    return r;
  endfunction

endpackage

[hdl/tdd_queue.sv]
// ----------------------------------------------------------------------------
// Tile damage detector job queue
// A short first-in first-out queue of tile row jobs between front and back.
// ----------------------------------------------------------------------------
module tdd_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("queue count exceeds its depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("queue popped while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push_i && !pop_i) |=> !empty_o)
    else $error("queue empty after a push");

endmodule

[hdl/tdd_front.sv]
// ----------------------------------------------------------------------------
// Tile damage detector front end
// Accepts pixel pairs, tracks raster position and marks dirty tile columns.
// ----------------------------------------------------------------------------
module tdd_front #(
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tdd_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tdd_pkg::PixW-1:0]          current_pixel_i,
  input  logic [tdd_pkg::PixW-1:0]          previous_pixel_i,
  input  logic                              queue_full_i,
  output logic                              push_o,
  output logic [MAX_COLS-1:0]               push_mask_o,
  output tdd_pkg::job_info_t                push_info_o
);
  import tdd_pkg::*;

  localparam int unsigned ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic [ColW-1:0] LastCol = ColW'(MAX_COLS - 1);

  logic [CoordW-1:0]   pix_col_q, pix_col_d;
  logic [CoordW-1:0]   pix_line_q, pix_line_d;
  logic [ColW-1:0]     tile_col_q, tile_col_d;
  logic [CoordW-1:0]   off_x_q, off_x_d;
  logic [CoordW-1:0]   off_y_q, off_y_d;
  logic [CoordW-1:0]   row_top_q, row_top_d;
  logic [MAX_COLS-1:0] dirty_q, dirty_d;

  logic                accept;
  logic [PixW-1:0]     byte_mask;
  logic                differs;
  logic [MAX_COLS-1:0] hit;
  logic [MAX_COLS-1:0] dirty_now;
  logic                line_end;
  logic                frame_end;
  logic                row_end;
  logic [CoordW-1:0]   next_line;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      byte_mask[8*k +: 8] = (PbW'(k) < cfg_i.pb) ? 8'hFF : 8'h00;
    end
    differs = |((current_pixel_i ^ previous_pixel_i) & byte_mask);
    for (int c = 0; c < MAX_COLS; c++) begin
      hit[c] = differs && (tile_col_q == ColW'(c));
    end
  end

  assign dirty_now = dirty_q | hit;
  assign line_end  = {1'b0, pix_col_q} >= (cfg_i.sw - DimW'(1));
  assign frame_end = line_end && ({1'b0, pix_line_q} >= (cfg_i.sh - DimW'(1)));
  assign row_end   = line_end && (frame_end || ({1'b0, off_y_q} >= (cfg_i.th - DimW'(1))));
  assign next_line = pix_line_q + CoordW'(1);

  assign push_o = accept && row_end && (cfg_i.hp ? (|dirty_now) : frame_end);
  assign push_mask_o           = dirty_now;
  assign push_info_o.top       = row_top_q;
  assign push_info_o.height    = {1'b0, off_y_q} + DimW'(1);
  assign push_info_o.frame_end = frame_end;
  assign push_info_o.full      = !cfg_i.hp;

  always_comb begin
    pix_col_d  = pix_col_q;
    pix_line_d = pix_line_q;
    tile_col_d = tile_col_q;
    off_x_d    = off_x_q;
    off_y_d    = off_y_q;
    row_top_d  = row_top_q;
    dirty_d    = dirty_q;
    if (accept) begin
      dirty_d = row_end ? '0 : dirty_now;
      if (line_end) begin
        pix_col_d  = '0;
        tile_col_d = '0;
        off_x_d    = '0;
        if (frame_end) begin
          pix_line_d = '0;
          off_y_d    = '0;
          row_top_d  = '0;
        end else begin
          pix_line_d = next_line;
          if (row_end) begin
            off_y_d   = '0;
            row_top_d = next_line;
          end else begin
            off_y_d = off_y_q + CoordW'(1);
          end
        end
      end else begin
        pix_col_d = pix_col_q + CoordW'(1);
        if ({1'b0, off_x_q} >= (cfg_i.tw - DimW'(1))) begin
          off_x_d = '0;
          if (tile_col_q < LastCol) begin
            tile_col_d = tile_col_q + ColW'(1);
          end
        end else begin
          off_x_d = off_x_q + CoordW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_col_q  <= '0;
      pix_line_q <= '0;
      tile_col_q <= '0;
      off_x_q    <= '0;
      off_y_q    <= '0;
      row_top_q  <= '0;
      dirty_q    <= '0;
    end else begin
      pix_col_q  <= pix_col_d;
      pix_line_q <= pix_line_d;
      tile_col_q <= tile_col_d;
      off_x_q    <= off_x_d;
      off_y_q    <= off_y_d;
      row_top_q  <= row_top_d;
      dirty_q    <= dirty_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) tile_col_q <= LastCol)
    else $error("tile column index beyond the last column");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (accept && row_end) |=> (dirty_q == '0))
    else $error("dirty flags not cleared at the end of a tile row");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (accept && line_end) |=> (pix_col_q == '0 && off_x_q == '0))
    else $error("column counters not cleared at the end of a line");

endmodule

[hdl/tdd_back.sv]
// ----------------------------------------------------------------------------
// Tile damage detector back end
// Scans a tile row job one tile column per cycle while the output is not stalled, and issues rectangles.
// ----------------------------------------------------------------------------
module tdd_back #(
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tdd_pkg::cfg_t                cfg_i,
  input  logic                         job_valid_i,
  input  logic [MAX_COLS-1:0]          job_mask_i,
  input  tdd_pkg::job_info_t           job_info_i,
  output logic                         job_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tdd_pkg::CoordW-1:0]   rect_x_o,
  output logic [tdd_pkg::CoordW-1:0]   rect_y_o,
  output logic [tdd_pkg::DimW-1:0]     rect_width_o,
  output logic [tdd_pkg::DimW-1:0]     rect_height_o,
  output logic                         last_in_run_o,
  output logic                         frame_done_o
);
  import tdd_pkg::*;

  localparam int unsigned ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic [ColW-1:0] LastCol = ColW'(MAX_COLS - 1);

  logic                scan_q;
  logic                full_q;
  logic [MAX_COLS-1:0] mask_q;
  logic [ColW-1:0]     col_q;
  logic [DimW:0]       x_q;
  logic [CoordW-1:0]   top_q;
  logic [DimW-1:0]     height_q;
  logic                fe_q;
  logic                hold_q;
  logic [CoordW-1:0]   hold_x_q;
  logic [DimW-1:0]     hold_w_q;

  logic                out_valid_q;
  logic [CoordW-1:0]   rect_x_q;
  logic [CoordW-1:0]   rect_y_q;
  logic [DimW-1:0]     rect_w_q;
  logic [DimW-1:0]     rect_h_q;
  logic                last_q;
  logic                done_q;

  logic                advance;
  logic [MAX_COLS-1:0] rest;
  logic [DimW:0]       x_next;
  logic                in_surface;
  logic                found;
  logic                flush;
  logic                emit_full;
  logic                emit_held;
  logic                last_col;
  logic                scan_done;
  logic [DimW-1:0]     w_raw;
  logic [DimW-1:0]     w_clip;

  // A found rectangle waits in the holding register until the next one is
  // found or the scan ends, so that the last one of the row can be marked.
  assign advance    = !out_valid_q || out_ready_i;
  assign job_pop_o  = !scan_q && !hold_q && job_valid_i;
  assign rest       = mask_q >> 1;
  assign x_next     = x_q + {1'b0, cfg_i.tw};
  assign in_surface = x_q < {1'b0, cfg_i.sw};
  assign found      = scan_q && !full_q && mask_q[0] && in_surface;
  assign flush      = !scan_q && hold_q;
  assign emit_full  = advance && scan_q && full_q;
  assign emit_held  = advance && hold_q && (found || flush);
  assign last_col   = (rest == '0) || (x_next >= {1'b0, cfg_i.sw});
  assign scan_done  = full_q || !in_surface || last_col;
  assign w_raw      = cfg_i.sw - x_q[DimW-1:0];
  assign w_clip     = ((col_q != LastCol) && (w_raw > cfg_i.tw)) ? cfg_i.tw : w_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= 1'b0;
      full_q      <= 1'b0;
      hold_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_pop_o) begin
        scan_q <= 1'b1;
        full_q <= job_info_i.full;
      end else if (scan_q && advance && scan_done) begin
        scan_q <= 1'b0;
      end
      if (advance && found) begin
        hold_q <= 1'b1;
      end else if (advance && flush) begin
        hold_q <= 1'b0;
      end
      if (emit_full || emit_held) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      mask_q   <= job_mask_i;
      col_q    <= '0;
      x_q      <= '0;
      top_q    <= job_info_i.top;
      height_q <= job_info_i.height;
      fe_q     <= job_info_i.frame_end;
    end else if (scan_q && advance) begin
      mask_q <= rest;
      col_q  <= col_q + ColW'(1);
      x_q    <= x_next;
    end
    if (advance && found) begin
      hold_x_q <= x_q[CoordW-1:0];
      hold_w_q <= w_clip;
    end
    if (emit_full) begin
      rect_x_q <= '0;
      rect_y_q <= '0;
      rect_w_q <= cfg_i.sw;
      rect_h_q <= cfg_i.sh;
      last_q   <= 1'b1;
      done_q   <= 1'b1;
    end else if (emit_held) begin
      rect_x_q <= hold_x_q;
      rect_y_q <= top_q;
      rect_w_q <= hold_w_q;
      rect_h_q <= height_q;
      last_q   <= flush;
      done_q   <= fe_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rect_x_o      = rect_x_q;
  assign rect_y_o      = rect_y_q;
  assign rect_width_o  = rect_w_q;
  assign rect_height_o = rect_h_q;
  assign last_in_run_o = last_q;
  assign frame_done_o  = done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (scan_q && full_q && advance) |=> (out_valid_q && last_q && done_q))
    else $error("whole surface request not issued as a final rectangle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !last_q) |-> hold_q)
    else $error("a non-final rectangle was issued but nothing is held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q |-> (rect_w_q != '0 && rect_h_q != '0))
    else $error("rectangle of zero size issued");

endmodule

[hdl/tile_damage_detector_core.sv]
// ----------------------------------------------------------------------------
// Tile damage detector core
// Compares current and previous frame pixels and reports damaged tiles.
// ----------------------------------------------------------------------------
// Throughput: one pixel pair per cycle; the input stalls only while the
// two-entry tile row queue is full.
// Each tile row job passes through the queue to the back end, which scans it
// column by column, holds each rectangle found until the next is found or the
// scan ends, and registers it onto the output.
// Reset: settings take their defaults; front counters, flags and queue clear.
module tile_damage_detector_core #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_DIM  = 8192
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tdd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tdd_pkg::DimW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tdd_pkg::PixW-1:0]      current_pixel_i,
  input  logic [tdd_pkg::PixW-1:0]      previous_pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tdd_pkg::CoordW-1:0]    rect_x_o,
  output logic [tdd_pkg::CoordW-1:0]    rect_y_o,
  output logic [tdd_pkg::DimW-1:0]      rect_width_o,
  output logic [tdd_pkg::DimW-1:0]      rect_height_o,
  output logic                          last_in_run_o,
  output logic                          frame_done_o
);
  import tdd_pkg::*;

  localparam logic [DimW-1:0] DimLim = DimW'((MAX_DIM < 8192) ? MAX_DIM : 8192);
  localparam int unsigned QueueW = MAX_COLS + JobInfoW;

  logic [DimW-1:0] surface_width_q;
  logic [DimW-1:0] surface_height_q;
  logic [DimW-1:0] tile_width_q;
  logic [DimW-1:0] tile_height_q;
  logic [PbW-1:0]  pixel_bytes_q;
  logic            have_previous_q;

  cfg_t cfg;

  logic                push;
  logic [MAX_COLS-1:0] push_mask;
  job_info_t           push_info;
  logic                pop;
  logic [QueueW-1:0]   queue_data;
  logic                queue_empty;
  logic                queue_full;
  logic [MAX_COLS-1:0] job_mask;
  job_info_t           job_info;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surface_width_q  <= DimW'(1920);
      surface_height_q <= DimW'(1080);
      tile_width_q     <= DimW'(64);
      tile_height_q    <= DimW'(64);
      pixel_bytes_q    <= PbW'(4);
      have_previous_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSurfaceWidth:  surface_width_q  <= cfg_data_i;
        RegSurfaceHeight: surface_height_q <= cfg_data_i;
        RegTileWidth:     tile_width_q     <= cfg_data_i;
        RegTileHeight:    tile_height_q    <= cfg_data_i;
        RegPixelBytes:    pixel_bytes_q    <= cfg_data_i[PbW-1:0];
        RegHavePrevious:  have_previous_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg.sw = clamp_dim(surface_width_q, DimLim);
  assign cfg.sh = clamp_dim(surface_height_q, DimLim);
  assign cfg.tw = clamp_dim(tile_width_q, DimLim);
  assign cfg.th = clamp_dim(tile_height_q, DimLim);
  assign cfg.pb = clamp_bytes(pixel_bytes_q);
  assign cfg.hp = have_previous_q;

  tdd_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .current_pixel_i  (current_pixel_i),
    .previous_pixel_i (previous_pixel_i),
    .queue_full_i     (queue_full),
    .push_o           (push),
    .push_mask_o      (push_mask),
    .push_info_o      (push_info)
  );

  tdd_queue #(
    .Width (QueueW),
    .Depth (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_mask, push_info}),
    .pop_i   (pop),
    .data_o  (queue_data),
    .empty_o (queue_empty),
    .full_o  (queue_full)
  );

  assign job_mask = queue_data[QueueW-1 -: MAX_COLS];
  assign job_info = queue_data[JobInfoW-1:0];

  tdd_back #(
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .job_valid_i   (!queue_empty),
    .job_mask_i    (job_mask),
    .job_info_i    (job_info),
    .job_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .rect_x_o      (rect_x_o),
    .rect_y_o      (rect_y_o),
    .rect_width_o  (rect_width_o),
    .rect_height_o (rect_height_o),
    .last_in_run_o (last_in_run_o),
    .frame_done_o  (frame_done_o)
  );

endmodule

[dv/tb_tile_damage_detector_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile damage detector core testbench
// Streams current and previous frame pixel pairs through the detector under
// a series of surface, tile and byte-count settings. A scoreboard predicts
// the damaged tile rectangles of each tile row and checks every rectangle
// that the block issues. Both handshakes idle at random, the output is held
// off long enough for the tile row queue to fill, and some settings lie
// outside the usual ranges.
// ----------------------------------------------------------------------------
module tb_tile_damage_detector_core;
  import tdd_pkg::*;

  localparam int unsigned MaxCols  = 64;
  localparam int unsigned MaxDim   = 8192;
  localparam int unsigned DimLimit = (MaxDim < 8192) ? MaxDim : 8192;
  localparam int RandomItems   = 230;
  localparam int SettleCycles  = 200;
  localparam int HoldoffCycles = 400;
  localparam int ReportLimit   = 50;

  typedef enum int {
    RxOpen,
    RxCoin,
    RxSparse,
    RxCadence
  } rx_mode_e;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [DimW-1:0]   w;
    logic [DimW-1:0]   h;
    logic              last_run;
    logic              frame_end;
  } damage_rect_t;

  class damage_scoreboard;
    damage_rect_t      pending_rects[$];
    int                fail_count;
    int                rect_count;
    logic [DimW-1:0]   reg_sw;
    logic [DimW-1:0]   reg_sh;
    logic [DimW-1:0]   reg_tw;
    logic [DimW-1:0]   reg_th;
    logic [PbW-1:0]    reg_pb;
    logic              reg_hp;
    bit                col_dirty[MaxCols];
    logic [CoordW-1:0] px_col;
    logic [CoordW-1:0] px_line;
    logic [CoordW-1:0] off_x;
    logic [CoordW-1:0] off_y;
    logic [CoordW-1:0] row_top;
    int unsigned       tile_col;

    function new();
      fail_count = 0;
      rect_count = 0;
      reg_sw = DimW'(1920);
      reg_sh = DimW'(1080);
      reg_tw = DimW'(64);
      reg_th = DimW'(64);
      reg_pb = PbW'(4);
      reg_hp = 1'b1;
      foreach (col_dirty[c]) col_dirty[c] = 1'b0;
      px_col = '0;
      px_line = '0;
      off_x = '0;
      off_y = '0;
      row_top = '0;
      tile_col = 0;
    endfunction

    function int unsigned eff_dim(logic [DimW-1:0] v);
      if (v == '0) return 1;
      if (v > DimLimit) return DimLimit;
      return v;
    endfunction

    function logic [PixW-1:0] byte_mask();
      int unsigned pb;
      pb = (reg_pb == '0) ? 1 : ((reg_pb > 4) ? 4 : reg_pb);
      return (pb >= 4) ? '1 : ((32'd1 << (8 * pb)) - 32'd1);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] data);
      case (idx)
        RegSurfaceWidth:  reg_sw = data;
        RegSurfaceHeight: reg_sh = data;
        RegTileWidth:     reg_tw = data;
        RegTileHeight:    reg_th = data;
        RegPixelBytes:    reg_pb = data[PbW-1:0];
        RegHavePrevious:  reg_hp = data[0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [PixW-1:0] cur, logic [PixW-1:0] prev);
      int unsigned  sw, sh, tw, th, x, w, lines, c;
      bit           line_end, frame_end, row_end, held;
      damage_rect_t r;
      sw = eff_dim(reg_sw);
      sh = eff_dim(reg_sh);
      tw = eff_dim(reg_tw);
      th = eff_dim(reg_th);
      held = 1'b0;
      if (((cur ^ prev) & byte_mask()) != '0) col_dirty[tile_col] = 1'b1;
      line_end = px_col >= sw - 1;
      frame_end = line_end && (px_line >= sh - 1);
      row_end = line_end && (frame_end || off_y >= th - 1);
      if (row_end) begin
        lines = off_y + 1;
        if (reg_hp) begin
          for (c = 0; c < MaxCols; c++) begin
            x = c * tw;
            if (col_dirty[c] && x < sw) begin
              w = sw - x;
              if (c != MaxCols - 1 && w > tw) w = tw;
              if (held) pending_rects.push_back(r);
              r.x = CoordW'(x);
              r.y = row_top;
              r.w = DimW'(w);
              r.h = DimW'(lines);
              r.last_run = 1'b0;
              r.frame_end = frame_end;
              held = 1'b1;
            end
          end
          if (held) begin
            r.last_run = 1'b1;
            pending_rects.push_back(r);
          end
        end else if (frame_end) begin
          r.x = '0;
          r.y = '0;
          r.w = DimW'(sw);
          r.h = DimW'(sh);
          r.last_run = 1'b1;
          r.frame_end = 1'b1;
          pending_rects.push_back(r);
        end
        foreach (col_dirty[k]) col_dirty[k] = 1'b0;
      end
      if (line_end) begin
        px_col = '0;
        tile_col = 0;
        off_x = '0;
        if (frame_end) begin
          px_line = '0;
          off_y = '0;
          row_top = '0;
        end else begin
          px_line = px_line + 1'b1;
          if (row_end) begin
            off_y = '0;
            row_top = px_line;
          end else begin
            off_y = off_y + 1'b1;
          end
        end
      end else begin
        px_col = px_col + 1'b1;
        if (off_x >= tw - 1) begin
          off_x = '0;
          if (tile_col < MaxCols - 1) tile_col++;
        end else begin
          off_x = off_x + 1'b1;
        end
      end
    endfunction

    task report(string msg);
      fail_count++;
      if (fail_count <= ReportLimit) $display("ERROR: %s", msg);
    endtask

    function string field_msg(string name, logic [31:0] want, logic [31:0] got);
      return $sformatf("rectangle %0d: %s expected %0d, got %0d",
                       rect_count, name, want, got);
    endfunction

    task check_rect(damage_rect_t got);
      damage_rect_t want;
      if (pending_rects.size() == 0) begin
        report($sformatf("rectangle x=%0d y=%0d issued with none outstanding",
                         got.x, got.y));
        return;
      end
      want = pending_rects.pop_front();
      if (got.x !== want.x) report(field_msg("rect_x", want.x, got.x));
      if (got.y !== want.y) report(field_msg("rect_y", want.y, got.y));
      if (got.w !== want.w) report(field_msg("rect_width", want.w, got.w));
      if (got.h !== want.h) report(field_msg("rect_height", want.h, got.h));
      if (got.last_run !== want.last_run) begin
        report(field_msg("last_in_run", want.last_run, got.last_run));
      end
      if (got.frame_end !== want.frame_end) begin
        report(field_msg("frame_done", want.frame_end, got.frame_end));
      end
      rect_count++;
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [DimW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [PixW-1:0]     current_pixel_i;
  logic [PixW-1:0]     previous_pixel_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [CoordW-1:0]   rect_x_o;
  logic [CoordW-1:0]   rect_y_o;
  logic [DimW-1:0]     rect_width_o;
  logic [DimW-1:0]     rect_height_o;
  logic                last_in_run_o;
  logic                frame_done_o;

  damage_scoreboard    sb;
  bit                  holdoff_req = 1'b0;
  int                  burst_left = 0;

  tile_damage_detector_core #(
    .MAX_COLS(MaxCols),
    .MAX_DIM (MaxDim)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .current_pixel_i (current_pixel_i),
    .previous_pixel_i(previous_pixel_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .rect_x_o        (rect_x_o),
    .rect_y_o        (rect_y_o),
    .rect_width_o    (rect_width_o),
    .rect_height_o   (rect_height_o),
    .last_in_run_o   (last_in_run_o),
    .frame_done_o    (frame_done_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_rects.size() != 0);
  endtask

  task automatic load_setup(input int sw, input int sh, input int tw, input int th,
                            input int pb, input int hp);
    logic [DimW-1:0] field;
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    put_reg(RegSurfaceWidth, DimW'(sw));
    put_reg(RegSurfaceHeight, DimW'(sh));
    put_reg(RegTileWidth, DimW'(tw));
    put_reg(RegTileHeight, DimW'(th));
    field = DimW'($urandom);
    field[PbW-1:0] = PbW'(pb);
    put_reg(RegPixelBytes, field);
    field = DimW'($urandom);
    field[0] = hp[0];
    put_reg(RegHavePrevious, field);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_pixel(input logic [PixW-1:0] cur, input logic [PixW-1:0] prev);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    current_pixel_i <= cur;
    previous_pixel_i <= prev;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_pixel(cur, prev);
  endtask

  // A damaged pair always differs in its lowest byte; a clean pair differs,
  // if at all, only in bytes that are not compared.
  task automatic send_pixels(input int count, input int rate);
    logic [PixW-1:0] cur, prev, mask;
    int              k;
    mask = sb.byte_mask();
    for (k = 0; k < count; k++) begin
      cur = $urandom;
      if ($urandom_range(0, 99) < rate) begin
        prev = cur ^ (($urandom & mask) | (32'd1 << $urandom_range(0, 7)));
      end else begin
        prev = cur ^ ($urandom & ~mask);
      end
      push_pixel(cur, prev);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      sb.check_rect({rect_x_o, rect_y_o, rect_width_o, rect_height_o,
                     last_in_run_o, frame_done_o});
    end
  end

  initial begin : rx_stall
    int       seg;
    int       hold;
    rx_mode_e mode;
    seg = 0;
    hold = 0;
    mode = RxOpen;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold = HoldoffCycles;
        out_ready_i <= 1'b0;
      end else begin
        if (seg == 0) begin
          seg = $urandom_range(8, 64);
          mode = rx_mode_e'($urandom_range(0, 3));
        end
        seg--;
        case (mode)
          RxOpen:   out_ready_i <= 1'b1;
          RxCoin:   out_ready_i <= 1'($urandom_range(0, 1));
          RxSparse: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:  out_ready_i <= (seg % 3 != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #(4_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int sw, sh, tw, th, pb, hp, rate, span, phase, kind, random_items;
    sb = new();
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= RegSurfaceWidth;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    current_pixel_i <= '0;
    previous_pixel_i <= '0;
    out_ready_i <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, then a change mid-line that ends the line at once.
    push_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    push_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_pixel(32'h0000_0000, 32'h0000_0000);
    load_setup(0, 0, 0, 0, 0, 1);
    push_pixel(32'h0000_00FF, 32'h0000_0000);
    push_pixel(32'hFFFF_FF00, 32'h0000_0000);
    push_pixel(32'h0000_0001, 32'h0000_0000);
    // Right edge tile clipped, byte count above range.
    load_setup(3, 2, 2, 2, 7, 1);
    push_pixel(32'hAB00_0000, 32'h0000_0000);
    send_pixels(1, 0);
    push_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_pixels(3, 0);
    // No previous frame: whole surface at frame end only.
    load_setup(3, 2, 2, 2, 2, 0);
    push_pixel(32'h0001_0000, 32'h0000_0000);
    send_pixels(5, 50);
    // Tile wider than the surface, three bytes compared.
    load_setup(2, 1, 5, 1, 3, 1);
    push_pixel(32'h0100_0000, 32'h0000_0000);
    push_pixel(32'h0080_0000, 32'h0000_0000);

    // Output held off while pixels keep coming, so that the row queue fills.
    load_setup(8, 8, 2, 1, 4, 1);
    holdoff_req = 1'b1;
    send_pixels(96, 60);
    random_items = 96;

    phase = 0;
    while (random_items < RandomItems) begin
      kind = (phase < 2) ? phase : $urandom_range(0, 7);
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 6);
      tw = $urandom_range(1, sw + 2);
      th = $urandom_range(1, sh + 1);
      pb = $urandom_range(0, 7);
      hp = ($urandom_range(0, 3) != 0);
      if (kind == 0) begin
        sw = $urandom_range(65, 96);
        sh = 1;
        tw = $urandom_range(0, 1);
      end else if (kind == 1) begin
        sw = $urandom_range(0, 6);
        tw = ($urandom_range(0, 1) != 0) ? 0 : 16383;
        th = ($urandom_range(0, 1) != 0) ? 0 : 16383;
      end
      case ($urandom_range(0, 3))
        0:       rate = 0;
        1:       rate = 100;
        default: rate = $urandom_range(5, 60);
      endcase
      load_setup(sw, sh, tw, th, pb, hp);
      span = sb.eff_dim(DimW'(sw)) * sb.eff_dim(DimW'(sh)) * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) span += $urandom_range(1, sb.eff_dim(DimW'(sw)));
      if (kind == 0) span = sb.eff_dim(DimW'(sw));
      if (span > RandomItems - random_items) span = RandomItems - random_items;
      if (phase == 0) begin
        send_pixels(span / 2, rate);
        drain_results();
        send_pixels(span - span / 2, rate);
      end else begin
        send_pixels(span, rate);
      end
      random_items += span;
      phase++;
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.pending_rects.size() != 0) begin
      sb.report($sformatf("%0d rectangles never issued", sb.pending_rects.size()));
    end
    if (sb.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[tile_damage_detector_core.f]
hdl/tdd_pkg.sv
hdl/tdd_queue.sv
hdl/tdd_front.sv
hdl/tdd_back.sv
hdl/tile_damage_detector_core.sv
dv/tb_tile_damage_detector_core.sv
